// ===== design/ptrp_pkg.sv =====
// package for the paper-tape reader and punch register block
// holds request/result types, operation and register codes, store sizes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptrp_pkg;

    localparam int TAPE_DEPTH  = 4096;
    localparam int PUNCH_DEPTH = 4096;

    localparam int TAPE_AW  = $clog2(TAPE_DEPTH);
    localparam int TAPE_CW  = $clog2(TAPE_DEPTH + 1);
    localparam int PUNCH_AW = $clog2(PUNCH_DEPTH);
    localparam int PUNCH_CW = $clog2(PUNCH_DEPTH + 1);

    localparam int PIDX_W = 12;
    localparam int PCMP_W = (PUNCH_CW > PIDX_W) ? PUNCH_CW : PIDX_W;

    localparam logic [2:0] OP_BUS_READ   = 3'd0;
    localparam logic [2:0] OP_BUS_WRITE  = 3'd1;
    localparam logic [2:0] OP_TAPE_CLEAR = 3'd2;
    localparam logic [2:0] OP_TAPE_APP   = 3'd3;
    localparam logic [2:0] OP_PUNCH_RB   = 3'd4;

    localparam logic [1:0] REG_RSTAT = 2'd0;
    localparam logic [1:0] REG_RBUF  = 2'd1;
    localparam logic [1:0] REG_PSTAT = 2'd2;
    localparam logic [1:0] REG_PBUF  = 2'd3;

    localparam int BIT_ERR  = 15;
    localparam int BIT_DONE = 7;
    localparam int BIT_IE   = 6;
    localparam int BIT_GO   = 0;

    typedef struct packed {
        logic [2:0]        operation;
        logic [1:0]        reg_select;
        logic [15:0]       write_data;
        logic [7:0]        tape_byte;
        logic [PIDX_W-1:0] punch_index;
    } t_req;

    typedef struct packed {
        logic [15:0] read_data;
        logic        reader_irq;
        logic        punch_irq;
        logic [12:0] punch_count;
        logic        punch_overflow;
    } t_res;

endpackage

`default_nettype wire

// ===== design/paper_tape_reader_punch_regs.sv =====
// top level of the paper-tape reader and punch register block
// depends on ptrp_pkg and ptrp_ram (tape store and punch store)
//
// usage:
//   one request channel (i_in_valid, i_in_req, o_in_stall) carries bus reads,
//   bus writes, tape clear, tape append and punch readback requests; one
//   result channel (o_out_valid, o_out_res, i_out_stall) returns one result
//   per request, in order.
//   a request is taken at the edge where i_in_valid is high and o_in_stall low.
//   the request edge issues the store access and updates all flags and counts;
//   the store read data is registered at that edge beside the request stage,
//   and the result register is loaded from that stage when it moves on, so
//   o_out_valid rises as the request passes into the result register.
//   one request per cycle while results are taken.
//   when the receiver stalls, the result register holds, one more request is
//   held in the stage behind it, and o_in_stall then rises.
//   reset clears all flags and counts and sets the reader error flag (no tape);
//   store contents are undefined and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module paper_tape_reader_punch_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire ptrp_pkg::t_req i_in_req,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output ptrp_pkg::t_res      o_out_res,
    input  wire logic           i_out_stall
);

    localparam int TCW = ptrp_pkg::TAPE_CW;
    localparam int PCW = ptrp_pkg::PUNCH_CW;
    localparam int TAW = ptrp_pkg::TAPE_AW;
    localparam int PAW = ptrp_pkg::PUNCH_AW;
    localparam int PMW = ptrp_pkg::PCMP_W;

    // architectural state
    logic [TCW-1:0] r_tlen, n_tlen;
    logic [TCW-1:0] r_tpos, n_tpos;
    logic [PCW-1:0] r_plen, n_plen;
    logic [7:0]     r_rbyte;
    logic           r_done, n_done;
    logic           r_err, n_err;
    logic           r_ren, n_ren;
    logic           r_pen, n_pen;
    logic           r_ovf, n_ovf;

    // pipeline
    logic           r_fetch_pend, n_fetch;
    logic           r_s1_valid;
    logic           r_s1_rb, n_rb;
    ptrp_pkg::t_res r_s1_res, n_res;
    logic           r_out_valid;
    ptrp_pkg::t_res r_out, n_out;

    // store ports
    logic           tape_we, tape_re, punch_we, punch_re;
    logic [TAW-1:0] tape_waddr, tape_raddr;
    logic [PAW-1:0] punch_waddr, punch_raddr;
    logic [7:0]     tape_rdata, punch_rdata;

    logic           accept, s1_move;
    logic [7:0]     cur_rbyte;
    logic [15:0]    rd;
    logic [PMW-1:0] pidx_ext, plen_ext;

    ptrp_ram #(.DEPTH(ptrp_pkg::TAPE_DEPTH), .WIDTH(8)) u_tape (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (i_in_req.tape_byte),
        .i_re    (tape_re),
        .i_raddr (tape_raddr),
        .o_rdata (tape_rdata)
    );

    ptrp_ram #(.DEPTH(ptrp_pkg::PUNCH_DEPTH), .WIDTH(8)) u_punch (
        .i_clk   (i_clk),
        .i_we    (punch_we),
        .i_waddr (punch_waddr),
        .i_wdata (i_in_req.write_data[7:0]),
        .i_re    (punch_re),
        .i_raddr (punch_raddr),
        .o_rdata (punch_rdata)
    );

    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign accept     = i_in_valid && !o_in_stall;

    // fetched byte is still in the tape read register while the fetch is pending
    assign cur_rbyte = r_fetch_pend ? tape_rdata : r_rbyte;

    assign pidx_ext    = PMW'(i_in_req.punch_index);
    assign plen_ext    = PMW'(r_plen);
    assign tape_waddr  = r_tlen[TAW-1:0];
    assign tape_raddr  = r_tpos[TAW-1:0];
    assign punch_waddr = r_plen[PAW-1:0];
    assign punch_raddr = PAW'(i_in_req.punch_index);

    always_comb begin
        n_tlen   = r_tlen;
        n_tpos   = r_tpos;
        n_plen   = r_plen;
        n_done   = r_done;
        n_err    = r_err;
        n_ren    = r_ren;
        n_pen    = r_pen;
        n_ovf    = r_ovf;
        n_fetch  = 1'b0;
        n_rb     = 1'b0;
        rd       = 16'h0000;
        tape_we  = 1'b0;
        tape_re  = 1'b0;
        punch_we = 1'b0;
        punch_re = 1'b0;
        if (accept) begin
            unique case (i_in_req.operation)
                ptrp_pkg::OP_BUS_READ: begin
                    unique case (i_in_req.reg_select)
                        ptrp_pkg::REG_RSTAT: begin
                            rd[ptrp_pkg::BIT_ERR]  = r_err;
                            rd[ptrp_pkg::BIT_DONE] = r_done;
                            rd[ptrp_pkg::BIT_IE]   = r_ren;
                        end
                        ptrp_pkg::REG_RBUF: begin
                            rd     = {8'h00, cur_rbyte};
                            n_done = 1'b0;
                        end
                        ptrp_pkg::REG_PSTAT: begin
                            rd[ptrp_pkg::BIT_DONE] = 1'b1;
                            rd[ptrp_pkg::BIT_IE]   = r_pen;
                        end
                        ptrp_pkg::REG_PBUF: begin
                            rd = 16'h0000;
                        end
                    endcase
                end
                ptrp_pkg::OP_BUS_WRITE: begin
                    unique case (i_in_req.reg_select)
                        ptrp_pkg::REG_RSTAT: begin
                            n_ren = i_in_req.write_data[ptrp_pkg::BIT_IE];
                            if (i_in_req.write_data[ptrp_pkg::BIT_GO]) begin
                                if (r_tpos < r_tlen) begin
                                    tape_re = 1'b1;
                                    n_fetch = 1'b1;
                                    n_tpos  = TCW'(r_tpos + TCW'(1));
                                    n_err   = 1'b0;
                                    n_done  = 1'b1;
                                end else begin
                                    n_done = 1'b0;
                                    n_err  = 1'b1;
                                end
                            end
                        end
                        ptrp_pkg::REG_RBUF: begin
                            n_ren = r_ren;
                        end
                        ptrp_pkg::REG_PSTAT: begin
                            n_pen = i_in_req.write_data[ptrp_pkg::BIT_IE];
                        end
                        ptrp_pkg::REG_PBUF: begin
                            if (r_plen < PCW'(ptrp_pkg::PUNCH_DEPTH)) begin
                                punch_we = 1'b1;
                                n_plen   = PCW'(r_plen + PCW'(1));
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    endcase
                end
                ptrp_pkg::OP_TAPE_CLEAR: begin
                    n_tlen = '0;
                    n_tpos = '0;
                    n_done = 1'b0;
                    n_err  = 1'b1;
                end
                ptrp_pkg::OP_TAPE_APP: begin
                    if (r_tlen < TCW'(ptrp_pkg::TAPE_DEPTH)) begin
                        tape_we = 1'b1;
                        n_tlen  = TCW'(r_tlen + TCW'(1));
                    end
                    n_tpos = '0;
                    n_done = 1'b0;
                    n_err  = 1'b0;
                end
                ptrp_pkg::OP_PUNCH_RB: begin
                    punch_re = 1'b1;
                    n_rb     = pidx_ext < plen_ext;
                end
                default: begin
                    n_rb = 1'b0;
                end
            endcase
        end
        n_res.read_data      = rd;
        n_res.reader_irq     = (n_done | n_err) & n_ren;
        n_res.punch_irq      = n_pen;
        n_res.punch_count    = 13'(n_plen);
        n_res.punch_overflow = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlen       <= '0;
            r_tpos       <= '0;
            r_plen       <= '0;
            r_rbyte      <= 8'h00;
            r_done       <= 1'b0;
            r_err        <= 1'b1;
            r_ren        <= 1'b0;
            r_pen        <= 1'b0;
            r_ovf        <= 1'b0;
            r_fetch_pend <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_tlen       <= n_tlen;
            r_tpos       <= n_tpos;
            r_plen       <= n_plen;
            r_done       <= n_done;
            r_err        <= n_err;
            r_ren        <= n_ren;
            r_pen        <= n_pen;
            r_ovf        <= n_ovf;
            r_fetch_pend <= n_fetch;
            if (r_fetch_pend) begin
                r_rbyte <= tape_rdata;
            end
            r_s1_valid  <= accept || (r_s1_valid && !s1_move);
            r_out_valid <= s1_move || (r_out_valid && i_out_stall);
        end
    end

    // punched byte joins the result on its way out
    always_comb begin
        n_out = r_s1_res;
        if (r_s1_rb) begin
            n_out.read_data = {8'h00, punch_rdata};
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res <= n_res;
            r_s1_rb  <= n_rb;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // overflow is sticky until reset
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("punch overflow flag cleared");

    a_done_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_err))
        else $error("reader done and error both set");

    a_plen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= PCW'(ptrp_pkg::PUNCH_DEPTH))
        else $error("punch length beyond store depth");

    a_fetch_in_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fetch_pend |-> r_s1_valid)
        else $error("tape fetch pending without request in flight");

    a_tpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tpos <= r_tlen)
        else $error("tape position beyond tape length");

endmodule

`default_nettype wire

// ===== design/ptrp_ram.sv =====
// single-port-write, single-port-read synchronous ram, registered read data
// used for the tape and punch stores; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module ptrp_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
